### src/tbp_pkg.sv
// tbp_pkg: shared types and constants of the tournament branch predictor
// used by tbp_front, tbp_back and the top module, no dependencies

package tbp_pkg;

    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int CTR_W        = 2;

    // default sizing of the prediction tables and the global history
    localparam int TABLE_ENTRIES_DEF = 2048;
    localparam int HISTORY_BITS_DEF  = 11;

    // queue between classifier and table pipeline, and the result queue
    localparam int MQ_DEPTH  = 4;
    localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // reset contents of the tables
    localparam logic [CTR_W-1:0] SEL_RESET = 2'd0;    // strongly gshare
    localparam logic [CTR_W-1:0] CNT_RESET = 2'd3;    // strongly taken
    localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
    localparam logic [CTR_W-1:0] CTR_TAKEN = 2'd2;    // taken at or above this

    // selector and bimodal counter share one word, selector in the upper half
    localparam int BS_W = 2 * CTR_W;
    localparam logic [BS_W-1:0] BS_RESET = {SEL_RESET, CNT_RESET};

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_in;

    typedef struct packed {
        logic               predicted_taken;
        logic               chose_bimodal;
        logic               prediction_correct;
        logic [COUNT_W-1:0] correct_total;
    } t_out;

    // saturating 2-bit counter step
    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c,
                                                   input logic up);
        logic [CTR_W-1:0] r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

### src/tbp_ram.sv
// tbp_ram: generic single-write, single-read memory with registered read data
// no dependencies; a read at the written address returns the old contents

module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tbp_fifo.sv
// tbp_fifo: small first-word-fall-through queue with an occupancy count
// no dependencies; used between classifier and tables, and for results

module tbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

### src/tbp_front.sv
// tbp_front: accepts branches, keeps the global history and reduces the
// bimodal and gshare indexes; depends on tbp_pkg

module tbp_front #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int JOB_W        = 2 * IDX_W + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  tbp_pkg::t_in                  i_item,
    input  logic                          i_clearing,
    input  logic [tbp_pkg::MQ_CNT_W-1:0]  i_mq_count,
    output logic                          o_job_push,
    output logic [JOB_W-1:0]              o_job
);

    localparam int AW    = tbp_pkg::ADDR_W;
    localparam int SHIFT = AW + IDX_W;
    localparam int PW    = AW + 34;
    localparam int CW    = tbp_pkg::MQ_CNT_W + 1;
    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    // reciprocal of the table size, exact quotient for any 32-bit value
    localparam logic [33:0] RECIP = 34'(((64'd1 << SHIFT) / TABLE_ENTRIES) + 64'd1);
    localparam logic [AW-1:0] TBL_N = AW'(TABLE_ENTRIES);

    logic                    accept;
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [AW-1:0]           x_gs;
    logic [PW-1:0]           prod_bi, prod_gs;

    logic                    r_s1_v;
    logic                    r_s1_taken;
    logic [AW-1:0]           r_s1_x_bi, r_s1_x_gs;
    logic [AW-1:0]           r_s1_q_bi, r_s1_q_gs;
    logic [AW-1:0]           qt_bi, qt_gs, rem_bi, rem_gs;
    logic [IDX_W-1:0]        idx_bi, idx_gs;

    // credit check: queue entries plus the item still in the reduce stage; also full while clearing
    assign o_full = i_clearing
                 || ((CW'(i_mq_count) + CW'(r_s1_v)) >= CW'(tbp_pkg::MQ_DEPTH));
    assign accept = i_push && !o_full;

    assign x_gs   = i_item.branch_address ^ AW'(r_hist);
    assign n_hist = HISTORY_BITS'({r_hist, i_item.taken});

    assign prod_bi = PW'(i_item.branch_address) * PW'(RECIP);
    assign prod_gs = PW'(x_gs) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            if (accept) begin
                r_hist <= n_hist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_taken <= i_item.taken;
            r_s1_x_bi  <= i_item.branch_address;
            r_s1_x_gs  <= x_gs;
            r_s1_q_bi  <= AW'(prod_bi >> SHIFT);
            r_s1_q_gs  <= AW'(prod_gs >> SHIFT);
        end
    end

    // remainder from the registered quotient
    assign qt_bi  = r_s1_q_bi * TBL_N;
    assign qt_gs  = r_s1_q_gs * TBL_N;
    assign rem_bi = r_s1_x_bi - qt_bi;
    assign rem_gs = r_s1_x_gs - qt_gs;

    assign idx_bi = IS_POW2 ? r_s1_x_bi[IDX_W-1:0] : rem_bi[IDX_W-1:0];
    assign idx_gs = IS_POW2 ? r_s1_x_gs[IDX_W-1:0] : rem_gs[IDX_W-1:0];

    assign o_job_push = r_s1_v;
    assign o_job      = {idx_bi, idx_gs, r_s1_taken};

endmodule

### src/tbp_back.sv
// tbp_back: clears the tables after reset, then reads, predicts and updates
// the selector, bimodal and gshare tables; depends on tbp_pkg and tbp_ram

module tbp_back #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int JOB_W        = 2 * IDX_W + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_clearing,
    input  logic                          i_mq_empty,
    input  logic [JOB_W-1:0]              i_job,
    output logic                          o_mq_pop,
    input  logic [tbp_pkg::OQ_CNT_W-1:0]  i_oq_count,
    output logic                          o_res_push,
    output tbp_pkg::t_out                 o_res
);

    localparam int BS_W = tbp_pkg::BS_W;
    localparam int C_W  = tbp_pkg::CTR_W;
    localparam int OCW  = tbp_pkg::OQ_CNT_W + 1;

    logic                        r_clr_busy;
    logic [IDX_W-1:0]            r_clr_idx;

    logic [IDX_W-1:0]            job_bi, job_gs;

    logic                        r_rd_v;
    logic [IDX_W-1:0]            r_rd_bi, r_rd_gs;
    logic                        r_rd_taken;

    logic                        r_fwd_v;
    logic [IDX_W-1:0]            r_fwd_bi, r_fwd_gs;
    logic [BS_W-1:0]             r_fwd_bs;
    logic [C_W-1:0]              r_fwd_gsc;

    logic [BS_W-1:0]             bs_rdata, bs_word, bs_new, bs_wdata;
    logic [C_W-1:0]              gs_rdata, gs_ctr, gs_new, gs_wdata;
    logic [C_W-1:0]              sel, bim, sel_new;
    logic                        bs_we, gs_we;
    logic [IDX_W-1:0]            bs_waddr, gs_waddr;

    logic                        bi_pred, gs_pred, bi_ok, gs_ok, use_bi, pred, ok;
    logic [tbp_pkg::COUNT_W-1:0] r_correct, n_correct;

    assign job_bi = i_job[2*IDX_W:IDX_W+1];
    assign job_gs = i_job[IDX_W:1];

    // issue a read only when the result queue has room for it
    assign o_mq_pop = !r_clr_busy && !i_mq_empty
                   && ((OCW'(i_oq_count) + OCW'(r_rd_v)) < OCW'(tbp_pkg::OQ_DEPTH));
    assign o_clearing = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_rd_v     <= 1'b0;
            r_fwd_v    <= 1'b0;
            r_correct  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_rd_v  <= o_mq_pop;
            r_fwd_v <= r_rd_v;
            if (r_rd_v) begin
                r_correct <= n_correct;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mq_pop) begin
            r_rd_bi    <= job_bi;
            r_rd_gs    <= job_gs;
            r_rd_taken <= i_job[0];
        end
        r_fwd_bi  <= r_rd_bi;
        r_fwd_gs  <= r_rd_gs;
        r_fwd_bs  <= bs_new;
        r_fwd_gsc <= gs_new;
    end

    // bypass the entry written at the same edge this read was taken
    assign bs_word = (r_fwd_v && (r_fwd_bi == r_rd_bi)) ? r_fwd_bs  : bs_rdata;
    assign gs_ctr  = (r_fwd_v && (r_fwd_gs == r_rd_gs)) ? r_fwd_gsc : gs_rdata;

    assign sel = bs_word[BS_W-1:C_W];
    assign bim = bs_word[C_W-1:0];

    assign bi_pred = (bim >= tbp_pkg::CTR_TAKEN);
    assign gs_pred = (gs_ctr >= tbp_pkg::CTR_TAKEN);
    assign bi_ok   = (bi_pred == r_rd_taken);
    assign gs_ok   = (gs_pred == r_rd_taken);
    assign use_bi  = (sel >= tbp_pkg::CTR_TAKEN);
    assign pred    = use_bi ? bi_pred : gs_pred;
    assign ok      = (pred == r_rd_taken);

    always_comb begin
        sel_new = sel;
        if (bi_ok && !gs_ok) begin
            sel_new = tbp_pkg::ctr_step(sel, 1'b1);
        end else if (!bi_ok && gs_ok) begin
            sel_new = tbp_pkg::ctr_step(sel, 1'b0);
        end
    end

    assign bs_new    = {sel_new, tbp_pkg::ctr_step(bim, r_rd_taken)};
    assign gs_new    = tbp_pkg::ctr_step(gs_ctr, r_rd_taken);
    assign n_correct = r_correct + tbp_pkg::COUNT_W'(ok);

    assign bs_we    = r_clr_busy || r_rd_v;
    assign gs_we    = r_clr_busy || r_rd_v;
    assign bs_waddr = r_clr_busy ? r_clr_idx : r_rd_bi;
    assign gs_waddr = r_clr_busy ? r_clr_idx : r_rd_gs;
    assign bs_wdata = r_clr_busy ? tbp_pkg::BS_RESET : bs_new;
    assign gs_wdata = r_clr_busy ? tbp_pkg::CNT_RESET : gs_new;

    tbp_ram #(
        .WIDTH (BS_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_bs_ram (
        .i_clk   (i_clk),
        .i_we    (bs_we),
        .i_waddr (bs_waddr),
        .i_wdata (bs_wdata),
        .i_re    (o_mq_pop),
        .i_raddr (job_bi),
        .o_rdata (bs_rdata)
    );

    tbp_ram #(
        .WIDTH (C_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_gs_ram (
        .i_clk   (i_clk),
        .i_we    (gs_we),
        .i_waddr (gs_waddr),
        .i_wdata (gs_wdata),
        .i_re    (o_mq_pop),
        .i_raddr (job_gs),
        .o_rdata (gs_rdata)
    );

    assign o_res_push               = r_rd_v;
    assign o_res.predicted_taken    = pred;
    assign o_res.chose_bimodal      = use_bi;
    assign o_res.prediction_correct = ok;
    assign o_res.correct_total      = n_correct;

endmodule

### src/tournament_branch_predictor_top.sv
// tournament_branch_predictor_top: bimodal / gshare tournament predictor
// depends on tbp_pkg, tbp_fifo, tbp_front, tbp_back (and tbp_ram below it)
//
// channel   direction  handshake            payload
// branch    in         push / full          i_item   (tbp_pkg::t_in)
// result    out        empty / pop          o_result (tbp_pkg::t_out)
//
// one branch per cycle sustained while results are popped; a result passes the index
// reduce stage, classify queue and table read before it shows on o_result,
// with the table write-back going through a one-entry bypass
// after reset, full stays high while the tables are swept
// a stalled result side fills the result queue and then the classify queue,
// after which full rises; nothing is dropped

module tournament_branch_predictor_top #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tbp_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output tbp_pkg::t_out o_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int JOB_W = 2 * IDX_W + 1;
    localparam int RES_W = $bits(tbp_pkg::t_out);

    logic                         clearing;
    logic                         job_push;
    logic [JOB_W-1:0]             job_in, job_out;
    logic                         mq_empty, mq_pop;
    logic [tbp_pkg::MQ_CNT_W-1:0] mq_count;
    logic                         res_push;
    tbp_pkg::t_out                res_in;
    logic [RES_W-1:0]             res_out;
    logic [tbp_pkg::OQ_CNT_W-1:0] oq_count;

    tbp_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_clearing (clearing),
        .i_mq_count (mq_count),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    tbp_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (tbp_pkg::MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (mq_pop),
        .o_data  (job_out),
        .o_empty (mq_empty),
        .o_count (mq_count)
    );

    tbp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_mq_empty (mq_empty),
        .i_job      (job_out),
        .o_mq_pop   (mq_pop),
        .i_oq_count (oq_count),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    tbp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tbp_pkg::OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (oq_count)
    );

    assign o_result = tbp_pkg::t_out'(res_out);

endmodule
